// ===== hdl/rxcbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rxcbc_pkg
// Shared constants and the single-round unscramble function for the
// rotate/xor chained block decryptor.
// ----------------------------------------------------------------------------
package rxcbc_pkg;

  localparam int BLK_W   = 64;
  localparam int BYTE_W  = 8;
  localparam int NBYTES  = BLK_W / BYTE_W;
  localparam int CFG_IDX_W = 2;
  localparam int ROT_AMT = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_FOLD    = 2'd2;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // one unscramble round; key_ofs is the round number mod 8
  function automatic blk_t rxcbc_round(input blk_t b, input blk_t key,
                                       input logic [2:0] key_ofs);
    byte_t      v [NBYTES];
    byte_t      x;
    logic [2:0] ki;
    logic [2:0] lower;
    blk_t       res;
    for (int i = 0; i < NBYTES; i++) begin
      v[i] = b[i*BYTE_W +: BYTE_W];
    end
    // bytes go from 7 down to 0, byte 0 sees the updated byte 7
    for (int i = NBYTES - 1; i >= 0; i--) begin
      lower = 3'(i) - 3'd1;
      x     = v[i] ^ v[lower];
      x     = {x[ROT_AMT-1:0], x[BYTE_W-1:ROT_AMT]};
      ki    = 3'(i) + key_ofs;
      x     = x ^ key[{ki, 3'b000} +: BYTE_W];
      v[i]  = x;
    end
    for (int i = 0; i < NBYTES; i++) begin
      res[i*BYTE_W +: BYTE_W] = v[i];
    end
    return res;
  endfunction

endpackage

// ===== hdl/rotxor_block_cbc_decrypt.sv =====
// ----------------------------------------------------------------------------
// rotxor_block_cbc_decrypt
// Chained rotate/xor decryption of 64-bit words, one round per pipeline stage.
// ----------------------------------------------------------------------------
// A word is taken in every cycle while the output side keeps up. The pipe is
// an input register, one register stage per round (ROUNDS stages) and an
// output register, through which each word passes in that order. The
// chain value is updated when the word is taken, since it only needs the
// ciphertext; the whole pipe holds when a finished word is not taken at the
// output. Configuration may only be written while the pipe is empty.
module rotxor_block_cbc_decrypt #(
  parameter int ROUNDS = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rxcbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rxcbc_pkg::BLK_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rxcbc_pkg::BLK_W-1:0]      in_cipher_block,
  input  logic                             in_first_block,
  input  logic                             in_whole_block,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rxcbc_pkg::BLK_W-1:0]      out_plain_block
);
  import rxcbc_pkg::*;

  logic en_r;
  blk_t key_r;
  blk_t fold_r;
  blk_t chain_r;
  blk_t chain_nxt;
  blk_t cv_use;
  logic pass_nxt;
  logic adv;
  logic in_fire;

  // stage 0 is the input register, stage k holds the word after k rounds
  logic s_vld_r  [ROUNDS+1];
  logic s_pass_r [ROUNDS+1];
  blk_t s_data_r [ROUNDS+1];
  blk_t s_blk_r  [ROUNDS+1];
  blk_t s_cv_r   [ROUNDS+1];
  blk_t rnd_nxt  [1:ROUNDS];

  logic out_valid_r;
  blk_t out_plain_r;
  blk_t out_plain_nxt;

  assign adv      = out_ready || !out_valid_r;
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      key_r  <= '0;
      fold_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DECRYPT_ENABLE: en_r   <= cfg_wr_data[0];
        CFG_CIPHER_KEY:     key_r  <= cfg_wr_data;
        CFG_DIGEST_FOLD:    fold_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // chain bookkeeping at intake
  always_comb begin
    cv_use    = in_first_block ? (key_r ^ fold_r) : chain_r;
    pass_nxt  = !(en_r && in_whole_block);
    chain_nxt = pass_nxt ? cv_use : in_cipher_block;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (in_fire) begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r[0] <= 1'b0;
    end else if (adv) begin
      s_vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_pass_r[0] <= pass_nxt;
      s_data_r[0] <= in_cipher_block;
      s_blk_r[0]  <= in_cipher_block;
      s_cv_r[0]   <= cv_use;
    end
  end

  for (genvar k = 1; k <= ROUNDS; k++) begin : g_round
    localparam logic [2:0] KOFS = 3'((ROUNDS - k) % NBYTES);

    assign rnd_nxt[k] = rxcbc_round(s_data_r[k-1], key_r, KOFS);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[k] <= 1'b0;
      end else if (adv) begin
        s_vld_r[k] <= s_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_pass_r[k] <= s_pass_r[k-1];
        s_data_r[k] <= rnd_nxt[k];
        s_blk_r[k]  <= s_blk_r[k-1];
        s_cv_r[k]   <= s_cv_r[k-1];
      end
    end
  end

  assign out_plain_nxt = s_pass_r[ROUNDS] ? s_blk_r[ROUNDS]
                                          : (s_data_r[ROUNDS] ^ s_cv_r[ROUNDS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_vld_r[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_plain_r <= out_plain_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_plain_block = out_plain_r;

  // a decrypted word leaves its ciphertext as the next chain value
  a_chain_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && en_r && in_whole_block |=> chain_r == $past(in_cipher_block))
    else $error("chain value not advanced to ciphertext");

  // a passed word with a reload leaves the iv as chain value
  a_chain_iv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_first_block && !(en_r && in_whole_block)
      |=> chain_r == $past(key_r ^ fold_r))
    else $error("chain value not reloaded from iv");

  // passed words leave unchanged
  a_pass_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s_vld_r[ROUNDS] && s_pass_r[ROUNDS]
      |=> out_plain_block == $past(s_blk_r[ROUNDS]))
    else $error("pass-through word altered");

  // a stall freezes the last round stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> s_vld_r[ROUNDS] == $past(s_vld_r[ROUNDS]))
    else $error("round stage moved during stall");

endmodule
